// File: rtl/ced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants for the escape decoder
// Beat structs for both channels, the result group and default parameters.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam logic [31:0] MAX_LEN_DEF = 32'd65535;

    // register select on paddr[2]
    localparam logic REG_ECHO   = 1'b0;
    localparam logic REG_STOP_C = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_string;
        logic        saw_stop;
        logic [15:0] total_len;
    } t_out_item;

    // up to three result beats from one input beat, item[0] goes out first
    typedef struct packed {
        logic [1:0]            n;
        t_out_item [2:0]       item;
    } t_res_set;

endpackage

// File: rtl/ced_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_step: escape scanner state and single-pass decode
// Holds the scan state and the running count, and turns one registered input
// beat into zero to three result beats combinationally.
// ----------------------------------------------------------------------------
module ced_step #(
    parameter logic [31:0] MAX_LEN = ced_pkg::MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ced_pkg::t_in_item i_item,
    input  logic              i_echo,
    input  logic              i_stop_c,
    output ced_pkg::t_res_set o_res
);

    localparam logic [15:0] CAP = (MAX_LEN > 32'd65535) ? 16'hFFFF : MAX_LEN[15:0];

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LC     = 8'h63;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] BEL       = 8'h07;
    localparam logic [7:0] BS        = 8'h08;
    localparam logic [7:0] ESC       = 8'h1B;
    localparam logic [7:0] FF        = 8'h0C;
    localparam logic [7:0] LF        = 8'h0A;
    localparam logic [7:0] CR        = 8'h0D;
    localparam logic [7:0] HT        = 8'h09;
    localparam logic [7:0] VT        = 8'h0B;

    typedef enum logic [4:0] {
        M_NORMAL = 5'b00001,
        M_BSLASH = 5'b00010,
        M_OCT    = 5'b00100,
        M_HEX    = 5'b01000,
        M_SKIP   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][7:0] b;
    } t_emits;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_val, n_val;
    logic [1:0]  r_dig, n_dig;
    logic [15:0] r_cnt, n_cnt;

    t_emits      w_e;
    logic        w_fin, w_stp, w_clr;
    logic [7:0]  w_c;
    logic        w_oct, w_hex;
    logic [3:0]  w_hval;
    logic [16:0] w_sum;
    logic [15:0] w_sat;
    logic [1:0]  w_nres;

    function automatic t_emits push(t_emits e, logic [7:0] b);
        t_emits r;
        r      = e;
        r.b[r.n] = b;
        r.n    = r.n + 2'd1;
        return r;
    endfunction

    // emits whatever escape is still open
    function automatic t_emits flush(t_emits e, t_mode m, logic [7:0] v, logic [1:0] d);
        t_emits r;
        r = e;
        unique case (m)
            M_BSLASH: r = push(r, CH_BSLASH);
            M_OCT:    r = push(r, v);
            M_HEX: begin
                if (d == 2'd0) begin
                    r = push(r, CH_BSLASH);
                    r = push(r, CH_LX);
                end else begin
                    r = push(r, v);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign w_c    = i_item.in_byte;
    assign w_oct  = (w_c[7:3] == 5'b00110);
    assign w_hex  = (w_c >= 8'h30 && w_c <= 8'h39) || (w_c >= 8'h61 && w_c <= 8'h66)
                 || (w_c >= 8'h41 && w_c <= 8'h46);
    assign w_hval = w_c[6] ? (w_c[3:0] + 4'd9) : w_c[3:0];

    always_comb begin
        logic use_b;
        logic done;
        n_mode = r_mode;
        n_val  = r_val;
        n_dig  = r_dig;
        w_e    = '0;
        w_fin  = 1'b0;
        w_stp  = 1'b0;
        w_clr  = 1'b0;
        use_b  = 1'b1;
        done   = 1'b0;
        if (r_mode == M_SKIP) begin
            if (i_item.in_last) begin
                n_mode = M_NORMAL;
                w_clr  = 1'b1;
            end
        end else if (w_c == CH_NUL) begin
            w_e    = flush(w_e, r_mode, r_val, r_dig);
            n_mode = i_item.in_last ? M_NORMAL : M_SKIP;
            n_val  = '0;
            n_dig  = '0;
            w_fin  = 1'b1;
        end else begin
            unique case (r_mode)
                M_OCT: begin
                    if (w_oct) begin
                        n_val = {r_val[4:0], w_c[2:0]};
                        n_dig = r_dig + 2'd1;
                        use_b = 1'b0;
                        if (n_dig == 2'd3) begin
                            w_e    = flush(w_e, n_mode, n_val, n_dig);
                            n_mode = M_NORMAL;
                            n_val  = '0;
                            n_dig  = '0;
                        end
                    end else begin
                        w_e    = flush(w_e, n_mode, n_val, n_dig);
                        n_mode = M_NORMAL;
                        n_val  = '0;
                        n_dig  = '0;
                    end
                end
                M_HEX: begin
                    if (w_hex) begin
                        n_val = {r_val[3:0], w_hval};
                        n_dig = r_dig + 2'd1;
                        use_b = 1'b0;
                        if (n_dig == 2'd2) begin
                            w_e    = flush(w_e, n_mode, n_val, n_dig);
                            n_mode = M_NORMAL;
                            n_val  = '0;
                            n_dig  = '0;
                        end
                    end else begin
                        w_e    = flush(w_e, n_mode, n_val, n_dig);
                        n_mode = M_NORMAL;
                        n_val  = '0;
                        n_dig  = '0;
                    end
                end
                M_BSLASH: begin
                    use_b  = 1'b0;
                    n_mode = M_NORMAL;
                    if (w_oct) begin
                        n_mode = M_OCT;
                        n_val  = {5'b0, w_c[2:0]};
                        n_dig  = 2'd1;
                    end else begin
                        unique case (w_c)
                            CH_LA:        w_e = push(w_e, BEL);
                            CH_LB:        w_e = push(w_e, BS);
                            CH_LE, CH_UE: w_e = push(w_e, ESC);
                            CH_LF:        w_e = push(w_e, FF);
                            CH_LN:        w_e = push(w_e, LF);
                            CH_LR:        w_e = push(w_e, CR);
                            CH_LT:        w_e = push(w_e, HT);
                            CH_LV:        w_e = push(w_e, VT);
                            CH_LX: begin
                                n_mode = M_HEX;
                                n_val  = '0;
                                n_dig  = '0;
                            end
                            CH_BSLASH:    w_e = push(w_e, CH_BSLASH);
                            CH_QUOTE: begin
                                if (i_echo) w_e = push(w_e, CH_BSLASH);
                                w_e = push(w_e, CH_QUOTE);
                            end
                            CH_LC: begin
                                if (i_stop_c) begin
                                    w_fin  = 1'b1;
                                    w_stp  = 1'b1;
                                    n_mode = i_item.in_last ? M_NORMAL : M_SKIP;
                                    done   = 1'b1;
                                end else begin
                                    w_e = push(w_e, CH_BSLASH);
                                    w_e = push(w_e, w_c);
                                end
                            end
                            default: begin
                                w_e = push(w_e, CH_BSLASH);
                                w_e = push(w_e, w_c);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            if (!done) begin
                if (use_b) begin
                    if (w_c == CH_BSLASH) n_mode = M_BSLASH;
                    else                  w_e = push(w_e, w_c);
                end
                if (i_item.in_last) begin
                    w_e    = flush(w_e, n_mode, n_val, n_dig);
                    n_mode = M_NORMAL;
                    n_val  = '0;
                    n_dig  = '0;
                    w_fin  = 1'b1;
                end
            end
        end
    end

    // saturating count including the bytes of this beat
    assign w_sum  = {1'b0, r_cnt} + {15'b0, w_e.n};
    assign w_sat  = (w_sum > {1'b0, CAP}) ? CAP : w_sum[15:0];
    assign n_cnt  = (w_fin || w_clr) ? 16'd0 : w_sat;
    assign w_nres = (w_fin && w_e.n == 2'd0) ? 2'd1 : w_e.n;

    always_comb begin
        o_res.n = i_fire ? w_nres : 2'd0;
        for (int k = 0; k < 3; k++) begin
            o_res.item[k].byte_valid    = (2'(k) < w_e.n);
            o_res.item[k].out_byte      = (2'(k) < w_e.n) ? w_e.b[k] : 8'h00;
            o_res.item[k].end_of_string = w_fin && (2'(k) == w_nres - 2'd1);
            o_res.item[k].saw_stop      = w_fin && w_stp && (2'(k) == w_nres - 2'd1);
            o_res.item[k].total_len     = (w_fin && (2'(k) == w_nres - 2'd1)) ? w_sat : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_val  <= '0;
            r_dig  <= '0;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_dig  <= n_dig;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: rtl/ced_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_outbuf: three-slot result register
// Loads all result beats of one input beat at once and shifts them out one
// beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ced_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ced_pkg::t_res_set  i_res,
    input  logic               i_stall,
    output logic               o_valid,
    output ced_pkg::t_out_item o_item,
    output logic               o_room
);

    ced_pkg::t_out_item [2:0] r_slot;
    logic [1:0]               r_cnt;
    logic                     w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[0];
    assign w_pop   = o_valid && !i_stall;
    // empty, or the last beat leaves this cycle
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_res.n;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res.item;
        end else if (w_pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

// File: rtl/c_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_decoder: streaming expander of C backslash escapes
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out (t_out_item)
//   config  | input     | APB psel/penable/pwrite   | paddr[2], pwdata[0]
//
// An input beat is registered, decoded combinationally and loaded into a
// three-slot result register, which presents its results in order.
// One input beat per cycle while each yields at most one result and the output
// is not stalled; a beat with more results holds the input until they drain.
// Reset clears scan state, count and both config bits.
// Output stall backs up into o_in_stall through the result register.
// ----------------------------------------------------------------------------
module c_escape_decoder #(
    parameter logic [31:0] MAX_LEN = ced_pkg::MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ced_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ced_pkg::t_out_item o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic              r_echo, r_stop_c;
    logic              r_in_valid;
    ced_pkg::t_in_item r_in;
    logic              w_room, w_fire, w_wr;
    ced_pkg::t_res_set w_res;

    // config registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = {31'b0, (paddr[2] == ced_pkg::REG_STOP_C) ? r_stop_c : r_echo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo   <= 1'b0;
            r_stop_c <= 1'b0;
        end else if (w_wr) begin
            if (paddr[2] == ced_pkg::REG_ECHO) r_echo   <= pwdata[0];
            else                               r_stop_c <= pwdata[0];
        end
    end

    // input register
    assign w_fire     = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
    end

    ced_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_echo   (r_echo),
        .i_stop_c (r_stop_c),
        .o_res    (w_res)
    );

    ced_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out),
        .o_room  (w_room)
    );

endmodule

// File: bench/c_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_decoder_tb: self-checking bench for the C escape decoder
// A short directed set of strings comes first, then random well-formed escape
// strings mixed with noise, under all four register settings and under sender
// gaps, receiver stalls and a long receiver hold-off.
// A built-in expander predicts every output beat; each beat is checked in order.
// ----------------------------------------------------------------------------
module c_escape_decoder_tb;

    localparam logic [31:0] SAT_LEN       = 32'd255;  // length cap given to the DUT and the checker
    localparam int          SETTLE_CYCLES = 10;
    localparam int          HOLD_CYCLES   = 60;

    localparam logic [7:0] C_BEL    = 8'h07;
    localparam logic [7:0] C_BKSP   = 8'h08;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_ESC    = 8'h1B;
    localparam logic [7:0] C_QUOTE  = 8'h27;
    localparam logic [7:0] C_BSLASH = 8'h5C;

    typedef enum logic [5:0] {
        SCAN_TEXT      = 6'b000001,
        SCAN_BSLASH    = 6'b000010,
        SCAN_OCT       = 6'b000100,
        SCAN_HEX       = 6'b001000,
        SCAN_SKIP_STOP = 6'b010000,
        SCAN_SKIP_NUL  = 6'b100000
    } t_scan;

    // Expands input beats into expected output beats and checks them in order.
    class t_escape_check;
        ced_pkg::t_out_item expected_chars[$];
        int          errors;
        int          n_in;
        int          n_out;
        int          n_strings;
        int          n_stops;
        int          n_capped;
        bit          keep_quote_bs;
        bit          stop_on_c;
        t_scan       mode;
        logic [7:0]  esc_val;
        int          digits;
        logic [15:0] out_cnt;
        logic [15:0] cap;
        int          step_n;

        function new(logic [31:0] cap_len);
            cap = (cap_len > 32'hFFFF) ? 16'hFFFF : cap_len[15:0];
            keep_quote_bs = 1'b0;
            stop_on_c = 1'b0;
            mode = SCAN_TEXT;
            clear_run();
        endfunction

        function void set_reg(logic sel, bit val);
            if (sel == ced_pkg::REG_ECHO) keep_quote_bs = val;
            else stop_on_c = val;
        endfunction

        function void clear_run();
            esc_val = '0;
            digits = 0;
            out_cnt = '0;
        endfunction

        function void push_char(logic [7:0] b);
            ced_pkg::t_out_item r;
            r = '0;
            r.out_byte = b;
            r.byte_valid = 1'b1;
            expected_chars.push_back(r);
            step_n++;
            if (out_cnt < cap) out_cnt++;
        endfunction

        // end flag rides on the last char of this beat, or on an empty beat
        function void end_string(bit stopped);
            ced_pkg::t_out_item r;
            if (step_n == 0) begin
                r = '0;
                expected_chars.push_back(r);
                step_n = 1;
            end
            r = expected_chars.pop_back();
            r.end_of_string = 1'b1;
            r.saw_stop = stopped;
            r.total_len = out_cnt;
            expected_chars.push_back(r);
            n_strings++;
            if (stopped) n_stops++;
            if (out_cnt == cap) n_capped++;
            clear_run();
        endfunction

        function void flush_escape();
            case (mode)
                SCAN_BSLASH: push_char(C_BSLASH);
                SCAN_OCT: push_char(esc_val);
                SCAN_HEX: begin
                    if (digits == 0) begin
                        push_char(C_BSLASH);
                        push_char("x");
                    end else begin
                        push_char(esc_val);
                    end
                end
                default: ;
            endcase
            mode = SCAN_TEXT;
            esc_val = '0;
            digits = 0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void expand_in_beat(ced_pkg::t_in_item it);
            logic [7:0] c;
            bit         last;
            bit         take;
            int         h;
            c = it.in_byte;
            last = it.in_last;
            take = 1'b1;
            step_n = 0;
            n_in++;
            if (mode == SCAN_SKIP_STOP || mode == SCAN_SKIP_NUL) begin
                if (last) begin
                    mode = SCAN_TEXT;
                    clear_run();
                end
                return;
            end
            if (c == 8'h00) begin
                flush_escape();
                end_string(1'b0);
                mode = last ? SCAN_TEXT : SCAN_SKIP_NUL;
                return;
            end
            case (mode)
                SCAN_OCT: begin
                    if (c >= "0" && c <= "7") begin
                        esc_val = {esc_val[4:0], c[2:0]};
                        digits++;
                        take = 1'b0;
                        if (digits >= 3) flush_escape();
                    end else begin
                        flush_escape();
                    end
                end
                SCAN_HEX: begin
                    h = hex_digit(c);
                    if (h >= 0) begin
                        esc_val = {esc_val[3:0], 4'(h)};
                        digits++;
                        take = 1'b0;
                        if (digits >= 2) flush_escape();
                    end else begin
                        flush_escape();
                    end
                end
                SCAN_BSLASH: begin
                    take = 1'b0;
                    mode = SCAN_TEXT;
                    case (c)
                        "a": push_char(C_BEL);
                        "b": push_char(C_BKSP);
                        "e", "E": push_char(C_ESC);
                        "f": push_char(C_FF);
                        "n": push_char(C_LF);
                        "r": push_char(C_CR);
                        "t": push_char(C_TAB);
                        "v": push_char(C_VT);
                        "0", "1", "2", "3", "4", "5", "6", "7": begin
                            mode = SCAN_OCT;
                            esc_val = {5'd0, c[2:0]};
                            digits = 1;
                        end
                        "x": begin
                            mode = SCAN_HEX;
                            esc_val = '0;
                            digits = 0;
                        end
                        C_BSLASH: push_char(C_BSLASH);
                        C_QUOTE: begin
                            if (keep_quote_bs) push_char(C_BSLASH);
                            push_char(C_QUOTE);
                        end
                        "c": begin
                            if (stop_on_c) begin
                                end_string(1'b1);
                                mode = last ? SCAN_TEXT : SCAN_SKIP_STOP;
                                return;
                            end
                            push_char(C_BSLASH);
                            push_char(c);
                        end
                        default: begin
                            push_char(C_BSLASH);
                            push_char(c);
                        end
                    endcase
                end
                default: ;
            endcase
            if (take) begin
                if (c == C_BSLASH) mode = SCAN_BSLASH;
                else push_char(c);
            end
            if (last) begin
                flush_escape();
                end_string(1'b0);
                mode = SCAN_TEXT;
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_out_beat(ced_pkg::t_out_item got);
            ced_pkg::t_out_item want;
            if (expected_chars.size() == 0) begin
                $error("output beat %0h with nothing expected", got);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            n_out++;
            check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
            check_field("end_of_string", 16'(want.end_of_string), 16'(got.end_of_string));
            check_field("saw_stop", 16'(want.saw_stop), 16'(got.saw_stop));
            check_field("total_len", want.total_len, got.total_len);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    ced_pkg::t_in_item  i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    ced_pkg::t_out_item o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    t_escape_check      sb;
    ced_pkg::t_in_item  beat_q[$];
    int unsigned        in_idle_pct;
    int unsigned        out_stall_pct;
    int                 beats_sent;
    logic               hold_go;
    logic               hold_done;

    c_escape_decoder #(
        .MAX_LEN(SAT_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(64'd5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.expand_in_beat(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.match_out_beat(o_out);
    end

    task automatic write_reg(input logic sel, input bit val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= ($urandom() & ~32'd1) | 32'(val);  // only bit 0 counts
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(sel, val);
    endtask

    task automatic set_regs(input bit echo, input bit stop_c);
        write_reg(ced_pkg::REG_ECHO, echo);
        write_reg(ced_pkg::REG_STOP_C, stop_c);
    endtask

    // valid stays high across back-to-back beats; it only drops for a gap
    task automatic send_beat(input ced_pkg::t_in_item b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    function automatic void add_byte(logic [7:0] b);
        ced_pkg::t_in_item t;
        t.in_byte = b;
        t.in_last = 1'b0;
        beat_q.push_back(t);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    task automatic send_string();
        ced_pkg::t_in_item b;
        b = beat_q.pop_back();
        b.in_last = 1'b1;
        beat_q.push_back(b);
        while (beat_q.size() != 0) begin
            b = beat_q.pop_front();
            send_beat(b);
        end
    endtask

    // mostly well-formed escapes with random content, some noise and zeros
    function automatic void build_text();
        string       named;
        string       hexd;
        int unsigned kind;
        logic [7:0]  b;
        named = "abeEfnrtv\\'";
        hexd = "0123456789abcdefABCDEF";
        repeat ($urandom_range(10, 1)) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                b = 8'($urandom_range(255, 1));
                add_byte((b == C_BSLASH) ? 8'("A") : b);
            end else if (kind < 50) begin
                add_byte(C_BSLASH);
                add_byte(named[$urandom_range(named.len() - 1)]);
            end else if (kind < 60) begin
                add_byte(C_BSLASH);
                repeat ($urandom_range(3, 1)) add_byte(8'("0" + $urandom_range(7)));
            end else if (kind < 70) begin
                add_byte(C_BSLASH);
                add_byte("x");
                repeat ($urandom_range(2)) add_byte(hexd[$urandom_range(21)]);
            end else if (kind < 75) begin
                add_byte(C_BSLASH);
                add_byte("c");
            end else if (kind < 85) begin
                add_byte(C_BSLASH);
                add_byte(8'($urandom_range(255, 1)));
            end else if (kind < 90) begin
                add_byte(8'h00);
            end else begin
                add_byte(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(9) == 0) add_byte(C_BSLASH);  // trailing lone backslash
    endfunction

    task automatic send_random(input int n_beats);
        int start;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            build_text();
            send_string();
        end
    endtask

    // let the last accepted beat reach the checker first, so it is already predicted
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sb = new(SAT_LEN);
        beats_sent = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_go = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings
        set_regs(1'b1, 1'b1);
        add_text("\\n\\x4g\\777\\'\\q\\");
        send_string();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("z");
        send_string();
        add_text("\\cxy");
        send_string();
        add_byte(8'hFF);
        add_text("\\x");
        send_string();
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            set_regs(ph[0], ph[1]);
            case (ph)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct = 78;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct = 78;
                end
                default: begin
                    in_idle_pct = 29;
                    out_stall_pct = 29;
                end
            endcase
            send_random(35);
            wait_idle();
        end

        // long receiver hold-off while the sender keeps pushing
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_go <= 1'b1;
        send_random(20);
        while (!hold_done) @(posedge i_clk);
        wait_idle();

        $display("Run covered %0d input beats in %0d strings, %0d output beats checked.",
                 sb.n_in, sb.n_strings, sb.n_out);
        $display("%0d strings stopped by backslash c, %0d reached the length cap of %0d.",
                 sb.n_stops, sb.n_capped, SAT_LEN);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: c_escape_decoder.f
rtl/ced_pkg.sv
rtl/ced_step.sv
rtl/ced_outbuf.sv
rtl/c_escape_decoder.sv
bench/c_escape_decoder_tb.sv
